// ----- rtl/i2cbm_pkg.sv -----
// Shared types, constants and phase tables for the I2C bit-level master.
`timescale 1ns / 1ps

package i2cbm_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [1:0] CFG_TICKS_PER_UNIT = 2'd0;
  localparam logic [1:0] CFG_ACK_POLL_LIMIT = 2'd1;
  localparam logic [1:0] CFG_LEAD_IN_UNITS  = 2'd2;

  localparam logic [15:0] RST_TICKS_PER_UNIT = 16'd500;
  localparam logic [7:0]  RST_ACK_POLL_LIMIT = 8'd200;
  localparam logic [7:0]  RST_LEAD_IN_UNITS  = 8'd50;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_sample;
  } cmd_item_t;

  typedef enum logic [21:0] {
    PH_IDLE     = 22'h000001,
    PH_S_A      = 22'h000002,
    PH_S_B      = 22'h000004,
    PH_S_C      = 22'h000008,
    PH_P_A      = 22'h000010,
    PH_P_B      = 22'h000020,
    PH_P_C      = 22'h000040,
    PH_W_LEAD   = 22'h000080,
    PH_W_DATA   = 22'h000100,
    PH_W_HIGH   = 22'h000200,
    PH_W_GAP    = 22'h000400,
    PH_W_POLL   = 22'h000800,
    PH_W_TAIL1  = 22'h001000,
    PH_W_TAIL2  = 22'h002000,
    PH_R_PRE    = 22'h004000,
    PH_R_REL    = 22'h008000,
    PH_R_HIGH   = 22'h010000,
    PH_R_SAMP   = 22'h020000,
    PH_R_LOW    = 22'h040000,
    PH_A_DATA   = 22'h080000,
    PH_A_HIGH   = 22'h100000,
    PH_A_LOW    = 22'h200000
  } phase_t;

  // Length of a fixed phase in delay units; lead-in is handled separately.
  function automatic logic [7:0] phase_units(input phase_t ph);
    logic [7:0] d;
    case (ph)
      PH_S_A, PH_S_B, PH_W_POLL, PH_W_TAIL1, PH_R_PRE, PH_R_REL, PH_R_SAMP: d = 8'd1;
      PH_IDLE, PH_W_LEAD: d = 8'd0;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  function automatic cmd_t classify(input logic [2:0] req);
    cmd_t c;
    case (req)
      REQ_START: c = CMD_START;
      REQ_STOP:  c = CMD_STOP;
      REQ_WRITE: c = CMD_WRITE;
      REQ_READ:  c = CMD_READ;
      default:   c = CMD_TICK;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/i2c_bit_level_master.sv -----
// Top level of the tick-driven I2C bit-level master.
// An item pushed is written into the input queue, stepped from there by the sequencer, and
// its result is written into the result queue (empty low), from where it can be popped.
// Throughput: one item per cycle while the result queue is not full; a full one stalls the step.
// Reset (rst_n low, synchronous): both queues empty, SCL and SDA released high,
// sequencer idle, config registers back to 500 / 200 / 50.
`timescale 1ns / 1ps

module i2c_bit_level_master import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic      cmd_valid;
  logic      cmd_pop;
  cmd_item_t cmd_item;
  logic      res_push;
  logic      res_full;
  out_item_t res_item;

  i2cbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop)
  );

  i2cbm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  i2cbm_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_item (res_item),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ----- rtl/i2cbm_front.sv -----
// Input queue: accepts items, decodes the request and buffers them for the sequencer.
`timescale 1ns / 1ps

module i2cbm_front import i2cbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      cmd_valid,
  output cmd_item_t cmd_item,
  input  logic      cmd_pop
);

  cmd_item_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;
  cmd_item_t          dec_item;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_item  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    dec_item.cmd        = classify(in_item.req_type);
    dec_item.data_byte  = in_item.data_byte;
    dec_item.ack_level  = in_item.ack_level;
    dec_item.sda_sample = in_item.sda_sample;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

// ----- rtl/i2cbm_seq.sv -----
// Bus sequencer: config registers, phase state machine and tick/unit timing.
`timescale 1ns / 1ps

module i2cbm_seq import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic       cmd_valid,
  input  cmd_item_t  cmd_item,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output out_item_t  res_item
);

  logic [15:0] tpu_r;
  logic [7:0]  poll_lim_r;
  logic [7:0]  lead_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  unit_r, unit_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        pend_ack_r, pend_ack_nxt;
  logic [7:0]  last_read_r, last_read_nxt;
  logic        ack_seen_r, ack_seen_nxt;

  logic        step;
  logic        rej, done, started, go_poll;
  logic [15:0] tpu_eff;
  logic [7:0]  lim_eff;
  logic [16:0] t_inc;
  logic [8:0]  u_inc;
  logic [7:0]  d_units;
  logic [3:0]  bi;
  logic [7:0]  pc;
  logic [7:0]  sh;

  assign step     = cmd_valid && !res_full;
  assign cmd_pop  = step;
  assign res_push = step;
  assign tpu_eff  = (tpu_r == '0) ? 16'd1 : tpu_r;
  assign lim_eff  = (poll_lim_r == '0) ? 8'd1 : poll_lim_r;

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    unit_nxt      = unit_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    pend_ack_nxt  = pend_ack_r;
    last_read_nxt = last_read_r;
    ack_seen_nxt  = ack_seen_r;
    rej           = 1'b0;
    done          = 1'b0;
    started       = 1'b0;
    go_poll       = 1'b0;
    t_inc         = {1'b0, tick_r} + 17'd1;
    u_inc         = {1'b0, unit_r} + 9'd1;
    d_units       = (phase_r == PH_W_LEAD) ? lead_r : phase_units(phase_r);
    bi            = bit_r + 4'd1;
    pc            = poll_r + 8'd1;
    sh            = {shift_r[6:0], 1'b0};

    if (cmd_item.cmd != CMD_TICK) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        started  = 1'b1;
        bit_nxt  = '0;
        poll_nxt = '0;
        tick_nxt = '0;
        unit_nxt = '0;
        case (cmd_item.cmd)
          CMD_START: begin
            phase_nxt = PH_S_A;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
          CMD_STOP: begin
            phase_nxt = PH_P_A;
            sda_nxt   = 1'b0;
          end
          CMD_WRITE: begin
            shift_nxt = cmd_item.data_byte;
            scl_nxt   = 1'b0;
            if (lead_r == '0) begin
              phase_nxt = PH_W_DATA;
              sda_nxt   = cmd_item.data_byte[7];
            end else begin
              phase_nxt = PH_W_LEAD;
            end
          end
          CMD_READ: begin
            shift_nxt    = '0;
            pend_ack_nxt = cmd_item.ack_level;
            phase_nxt    = PH_R_PRE;
            scl_nxt      = 1'b0;
            sda_nxt      = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    if (!started && phase_r != PH_IDLE) begin
      if (t_inc < {1'b0, tpu_eff}) begin
        tick_nxt = t_inc[15:0];
      end else begin
        tick_nxt = '0;
        if (u_inc >= {1'b0, d_units}) begin
          unit_nxt = '0;
          case (phase_r)
            PH_S_A: begin
              phase_nxt = PH_S_B;
              sda_nxt   = 1'b0;
            end
            PH_S_B: begin
              phase_nxt = PH_S_C;
              scl_nxt   = 1'b0;
            end
            PH_P_A: begin
              phase_nxt = PH_P_B;
              scl_nxt   = 1'b1;
            end
            PH_P_B: begin
              phase_nxt = PH_P_C;
              sda_nxt   = 1'b1;
            end
            PH_W_LEAD: begin
              phase_nxt = PH_W_DATA;
              scl_nxt   = 1'b0;
              sda_nxt   = shift_r[7];
            end
            PH_W_DATA: begin
              phase_nxt = PH_W_HIGH;
              scl_nxt   = 1'b1;
            end
            PH_W_HIGH: begin
              shift_nxt = sh;
              bit_nxt   = bi;
              scl_nxt   = 1'b0;
              if (bi >= BITS_PER_BYTE) begin
                phase_nxt = PH_W_GAP;
              end else begin
                phase_nxt = PH_W_DATA;
                sda_nxt   = sh[7];
              end
            end
            PH_W_GAP: begin
              go_poll = 1'b1;
            end
            PH_W_POLL: begin
              poll_nxt = pc;
              if (pc >= lim_eff || pc == '0) begin
                ack_seen_nxt = 1'b0;
                phase_nxt    = PH_W_TAIL1;
                scl_nxt      = 1'b1;
              end else begin
                go_poll = 1'b1;
              end
            end
            PH_W_TAIL1: begin
              phase_nxt = PH_W_TAIL2;
              scl_nxt   = 1'b0;
            end
            PH_R_PRE: begin
              phase_nxt = PH_R_REL;
            end
            PH_R_REL: begin
              phase_nxt = PH_R_HIGH;
              scl_nxt   = 1'b1;
            end
            PH_R_HIGH: begin
              phase_nxt = PH_R_SAMP;
              shift_nxt = {shift_r[6:0], cmd_item.sda_sample};
            end
            PH_R_SAMP: begin
              phase_nxt = PH_R_LOW;
              scl_nxt   = 1'b0;
            end
            PH_R_LOW: begin
              bit_nxt = bi;
              if (bi >= BITS_PER_BYTE) begin
                last_read_nxt = shift_r;
                phase_nxt     = PH_A_DATA;
                scl_nxt       = 1'b0;
                sda_nxt       = pend_ack_r;
              end else begin
                phase_nxt = PH_R_HIGH;
                scl_nxt   = 1'b1;
              end
            end
            PH_A_DATA: begin
              phase_nxt = PH_A_HIGH;
              scl_nxt   = 1'b1;
            end
            PH_A_HIGH: begin
              phase_nxt = PH_A_LOW;
              scl_nxt   = 1'b0;
            end
            default: begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          endcase
        end else begin
          unit_nxt = u_inc[7:0];
        end
      end
    end

    // ack poll entry: SDA low already on entry ends the poll at once
    if (go_poll) begin
      scl_nxt = 1'b1;
      sda_nxt = 1'b1;
      if (!cmd_item.sda_sample) begin
        ack_seen_nxt = 1'b1;
        phase_nxt    = PH_W_TAIL1;
      end else begin
        phase_nxt = PH_W_POLL;
      end
    end
  end

  always_comb begin
    res_item.scl_level    = scl_nxt;
    res_item.sda_level    = sda_nxt;
    res_item.busy_res     = (phase_nxt != PH_IDLE);
    res_item.done_res     = done;
    res_item.ack_received = ack_seen_nxt;
    res_item.read_data    = last_read_nxt;
    res_item.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r      <= RST_TICKS_PER_UNIT;
      poll_lim_r <= RST_ACK_POLL_LIMIT;
      lead_r     <= RST_LEAD_IN_UNITS;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TICKS_PER_UNIT: tpu_r      <= cfg_wdata;
        CFG_ACK_POLL_LIMIT: poll_lim_r <= cfg_wdata[7:0];
        CFG_LEAD_IN_UNITS:  lead_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      unit_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      pend_ack_r  <= 1'b0;
      last_read_r <= '0;
      ack_seen_r  <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      unit_r      <= unit_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      pend_ack_r  <= pend_ack_nxt;
      last_read_r <= last_read_nxt;
      ack_seen_r  <= ack_seen_nxt;
    end
  end

endmodule

// ----- rtl/i2cbm_outq.sv -----
// Result queue: holds finished result items until they are popped.
`timescale 1ns / 1ps

module i2cbm_outq import i2cbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_push,
  input  out_item_t res_item,
  output logic      res_full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  out_item_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign res_full = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign out_item = slot_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res_item;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the I2C bit-level master: queued ticks, predicted bus levels.
`timescale 1ns / 1ps

module tb_top;
  import i2cbm_pkg::*;

  localparam logic [2:0] REQ_CODE_MAX = 3'd7;

  typedef enum int {BUS_RANDOM, BUS_HIGH, BUS_LOW, BUS_NOISY_HIGH} bus_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  i2c_bit_level_master dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // pending ticks and predicted bus levels
  in_item_t  tick_q[$];
  out_item_t bus_exp_q[$];

  int fail_cnt = 0;
  int checked_cnt = 0;

  // sequencer shadow
  logic [15:0] cfg_tpu;
  logic [7:0]  cfg_lim;
  logic [7:0]  cfg_lead;
  phase_t      ph;
  logic [15:0] tick_cnt;
  logic [7:0]  unit_cnt;
  logic [3:0]  bit_idx;
  logic [7:0]  shift_reg;
  logic [7:0]  poll_cnt;
  logic        scl_q, sda_q, pend_ack, ack_seen, cur_sda, done_flag;
  logic [7:0]  last_rd;

  // handshake bookkeeping
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic offering = 1'b0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_done = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  int   hold_left = 0;
  int   tx_cnt = 0;
  int   rx_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic void seq_reset();
    cfg_tpu   = RST_TICKS_PER_UNIT;
    cfg_lim   = RST_ACK_POLL_LIMIT;
    cfg_lead  = RST_LEAD_IN_UNITS;
    ph        = PH_IDLE;
    tick_cnt  = '0;
    unit_cnt  = '0;
    bit_idx   = '0;
    shift_reg = '0;
    poll_cnt  = '0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    pend_ack  = 1'b0;
    last_rd   = '0;
    ack_seen  = 1'b0;
    cur_sda   = 1'b1;
    done_flag = 1'b0;
  endfunction

  function automatic int seq_units(input phase_t p);
    case (p)
      PH_W_LEAD: return int'(cfg_lead);
      PH_S_A, PH_S_B, PH_W_POLL, PH_W_TAIL1, PH_R_PRE, PH_R_REL, PH_R_SAMP: return 1;
      default: return 2;
    endcase
  endfunction

  function automatic void seq_enter(input phase_t p);
    ph = p;
    tick_cnt = '0;
    unit_cnt = '0;
    case (p)
      PH_S_A: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
      end
      PH_S_B, PH_P_A: sda_q = 1'b0;
      PH_P_C: sda_q = 1'b1;
      PH_P_B, PH_W_HIGH, PH_W_TAIL1, PH_R_HIGH, PH_A_HIGH: scl_q = 1'b1;
      PH_S_C, PH_W_GAP, PH_W_TAIL2, PH_R_LOW, PH_A_LOW: scl_q = 1'b0;
      PH_W_LEAD: begin
        scl_q = 1'b0;
        if (cfg_lead == 0) begin
          ph = PH_W_DATA;
          sda_q = shift_reg[7];
        end
      end
      PH_W_DATA: begin
        scl_q = 1'b0;
        sda_q = shift_reg[7];
      end
      PH_W_POLL: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        if (!cur_sda) begin
          ack_seen = 1'b1;
          ph = PH_W_TAIL1;
        end
      end
      PH_R_PRE: begin
        scl_q = 1'b0;
        sda_q = 1'b1;
      end
      PH_R_SAMP: shift_reg = {shift_reg[6:0], cur_sda};
      PH_A_DATA: begin
        scl_q = 1'b0;
        sda_q = pend_ack;
      end
      default: ;
    endcase
  endfunction

  function automatic void seq_unit_done();
    logic [7:0] lim;
    lim = (cfg_lim == 0) ? 8'd1 : cfg_lim;
    case (ph)
      PH_S_A: seq_enter(PH_S_B);
      PH_S_B: seq_enter(PH_S_C);
      PH_P_A: seq_enter(PH_P_B);
      PH_P_B: seq_enter(PH_P_C);
      PH_W_LEAD: seq_enter(PH_W_DATA);
      PH_W_DATA: seq_enter(PH_W_HIGH);
      PH_W_HIGH: begin
        shift_reg = shift_reg << 1;
        bit_idx = bit_idx + 4'd1;
        seq_enter(bit_idx >= BITS_PER_BYTE ? PH_W_GAP : PH_W_DATA);
      end
      PH_W_GAP: seq_enter(PH_W_POLL);
      PH_W_POLL: begin
        poll_cnt = poll_cnt + 8'd1;
        if (poll_cnt >= lim || poll_cnt == 0) begin
          ack_seen = 1'b0;
          seq_enter(PH_W_TAIL1);
        end else begin
          seq_enter(PH_W_POLL);
        end
      end
      PH_W_TAIL1: seq_enter(PH_W_TAIL2);
      PH_R_PRE: seq_enter(PH_R_REL);
      PH_R_REL: seq_enter(PH_R_HIGH);
      PH_R_HIGH: seq_enter(PH_R_SAMP);
      PH_R_SAMP: seq_enter(PH_R_LOW);
      PH_R_LOW: begin
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= BITS_PER_BYTE) begin
          last_rd = shift_reg;
          seq_enter(PH_A_DATA);
        end else begin
          seq_enter(PH_R_HIGH);
        end
      end
      PH_A_DATA: seq_enter(PH_A_HIGH);
      PH_A_HIGH: seq_enter(PH_A_LOW);
      default: begin
        ph = PH_IDLE;
        tick_cnt = '0;
        unit_cnt = '0;
        done_flag = 1'b1;
      end
    endcase
  endfunction

  function automatic void seq_count();
    int tpu, t, u;
    tpu = (cfg_tpu == 0) ? 1 : int'(cfg_tpu);
    t = int'(tick_cnt) + 1;
    if (t < tpu) begin
      tick_cnt = t[15:0];
      return;
    end
    tick_cnt = '0;
    u = int'(unit_cnt) + 1;
    if (u >= seq_units(ph)) seq_unit_done();
    else unit_cnt = u[7:0];
  endfunction

  function automatic out_item_t seq_step(input in_item_t it);
    out_item_t r;
    logic is_cmd, started, rej;
    is_cmd = 1'b0;
    started = 1'b0;
    rej = 1'b0;
    cur_sda = it.sda_sample;
    done_flag = 1'b0;
    case (it.req_type)
      REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: is_cmd = 1'b1;
      default: ;
    endcase
    if (is_cmd) begin
      if (ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        started = 1'b1;
        bit_idx = '0;
        poll_cnt = '0;
        case (it.req_type)
          REQ_START: seq_enter(PH_S_A);
          REQ_STOP: seq_enter(PH_P_A);
          REQ_WRITE: begin
            shift_reg = it.data_byte;
            seq_enter(PH_W_LEAD);
          end
          default: begin
            shift_reg = '0;
            pend_ack = it.ack_level;
            seq_enter(PH_R_PRE);
          end
        endcase
      end
    end
    if (!started && ph != PH_IDLE) seq_count();
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.busy_res     = (ph != PH_IDLE);
    r.done_res     = done_flag;
    r.ack_received = ack_seen;
    r.read_data    = last_rd;
    r.rejected     = rej;
    return r;
  endfunction

  function automatic int idle_len(input logic burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (bus_exp_q.size() == 0) begin
      $error("unexpected item on output: %0h", got);
      fail_cnt++;
      return;
    end
    want = bus_exp_q.pop_front();
    check_field("scl_level", want.scl_level, got.scl_level);
    check_field("sda_level", want.sda_level, got.sda_level);
    check_field("busy_res", want.busy_res, got.busy_res);
    check_field("done_res", want.done_res, got.done_res);
    check_field("ack_received", want.ack_received, got.ack_received);
    check_field("read_data", want.read_data, got.read_data);
    check_field("rejected", want.rejected, got.rejected);
    checked_cnt++;
  endtask

  // accept and check at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        bus_exp_q.push_back(seq_step(in_item));
        in_taken = 1'b1;
      end
      if (pop && !empty) begin
        out_taken = 1'b1;
        check_result(out_item);
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        offering = 1'b0;
        tx_wait = idle_len(tx_burst);
        tx_cnt++;
        if (tx_cnt % 128 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (tick_q.size() > 0) begin
          in_item <= tick_q.pop_front();
          offering = 1'b1;
        end
      end
      push <= offering;
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        rx_wait = idle_len(rx_burst);
        rx_cnt++;
        if (rx_cnt % 128 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
      if (!hold_done && checked_cnt >= 300 && tick_q.size() > 20) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic logic bus_sda(input bus_mode_t mode);
    case (mode)
      BUS_HIGH: return 1'b1;
      BUS_LOW: return 1'b0;
      BUS_NOISY_HIGH: return ($urandom_range(0, 7) != 0);
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic add_item(input logic [2:0] req, input logic [7:0] data,
                          input logic ack, input logic sda);
    in_item_t it;
    it.req_type = req;
    it.data_byte = data;
    it.ack_level = ack;
    it.sda_sample = sda;
    tick_q.push_back(it);
  endtask

  // command item followed by plain ticks; noisy ticks carry stray codes
  task automatic add_command(input logic [2:0] req, input logic [7:0] data, input logic ack,
                             input bus_mode_t mode, input int gap, input logic noisy);
    logic [2:0] r;
    int n;
    add_item(req, data, ack, bus_sda(mode));
    for (int i = 0; i < gap; i++) begin
      n = $urandom_range(0, 99);
      r = REQ_TICK;
      if (noisy && n < 3) r = 3'($urandom_range(REQ_READ + 1, REQ_CODE_MAX));
      else if (noisy && n < 6) r = 3'($urandom_range(REQ_START, REQ_READ));
      add_item(r, 8'($urandom), 1'($urandom), bus_sda(mode));
    end
  endtask

  // nominal length of a command in ticks under the current settings
  function automatic int cmd_ticks(input logic [2:0] req, input bus_mode_t mode);
    int tpu, lim, units;
    tpu = (cfg_tpu == 0) ? 1 : int'(cfg_tpu);
    lim = (cfg_lim == 0) ? 1 : int'(cfg_lim);
    case (req)
      REQ_START: units = 4;
      REQ_STOP: units = 6;
      REQ_READ: units = 48;
      REQ_WRITE: begin
        units = int'(cfg_lead) + 37;
        if (mode == BUS_HIGH) units += lim;
        else if (mode == BUS_NOISY_HIGH) units += (lim < 12) ? lim : 12;
        else units += 1;
      end
      default: units = 0;
    endcase
    return units * tpu + 1;
  endfunction

  task automatic random_phase(input int budget);
    int used, gap, r;
    logic [2:0] req;
    bus_mode_t mode;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 99);
      if (r < 20) req = REQ_START;
      else if (r < 40) req = REQ_STOP;
      else if (r < 70) req = REQ_WRITE;
      else if (r < 95) req = REQ_READ;
      else req = 3'($urandom_range(REQ_READ + 1, REQ_CODE_MAX));
      r = $urandom_range(0, 99);
      if (r < 50) mode = BUS_RANDOM;
      else if (r < 65) mode = BUS_HIGH;
      else if (r < 80) mode = BUS_LOW;
      else mode = BUS_NOISY_HIGH;
      gap = cmd_ticks(req, mode);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(0, gap);
      else gap += $urandom_range(0, 3);
      add_command(req, 8'($urandom), 1'($urandom), mode, gap, 1'b1);
      used += gap + 1;
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || offering || bus_exp_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TICKS_PER_UNIT: cfg_tpu = val;
      CFG_ACK_POLL_LIMIT: cfg_lim = val[7:0];
      CFG_LEAD_IN_UNITS: cfg_lead = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] tpu, input logic [7:0] lim,
                          input logic [7:0] lead);
    wait_drained();
    write_reg(CFG_TICKS_PER_UNIT, tpu);
    write_reg(CFG_ACK_POLL_LIMIT, {8'd0, lim});
    write_reg(CFG_LEAD_IN_UNITS, {8'd0, lead});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    seq_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset levels and a start at the default timing, busy commands rejected
    add_item(REQ_TICK, 8'h00, 1'b0, 1'b1);
    add_item(REQ_START, 8'hFF, 1'b1, 1'b1);
    add_item(REQ_WRITE, 8'hA5, 1'b0, 1'b0);
    add_item(REQ_TICK, 8'hFF, 1'b1, 1'b0);
    add_item(REQ_READ, 8'h00, 1'b1, 1'b1);

    // zero registers: one tick per unit, one ack sample, no lead-in
    set_regs(16'd0, 8'd0, 8'd0);
    add_command(REQ_STOP, 8'h3C, 1'b0, BUS_RANDOM, 5, 1'b0);
    add_command(REQ_STOP, 8'h00, 1'b0, BUS_RANDOM, cmd_ticks(REQ_STOP, BUS_RANDOM) + 2, 1'b0);
    add_command(REQ_WRITE, 8'hFF, 1'b0, BUS_LOW, cmd_ticks(REQ_WRITE, BUS_LOW) + 2, 1'b0);
    add_command(REQ_WRITE, 8'h00, 1'b1, BUS_HIGH, cmd_ticks(REQ_WRITE, BUS_HIGH) + 2, 1'b0);
    add_command(REQ_READ, 8'h5A, 1'b1, BUS_HIGH, cmd_ticks(REQ_READ, BUS_HIGH) + 2, 1'b0);
    add_command(REQ_READ, 8'hFF, 1'b0, BUS_LOW, cmd_ticks(REQ_READ, BUS_LOW) + 2, 1'b0);
    add_command(REQ_READ, 8'h00, 1'b0, BUS_RANDOM, cmd_ticks(REQ_READ, BUS_RANDOM) + 2, 1'b0);
    add_command(REQ_START, 8'h81, 1'b1, BUS_RANDOM,
                cmd_ticks(REQ_START, BUS_RANDOM) + 2, 1'b0);
    for (int c = REQ_READ + 1; c <= REQ_CODE_MAX; c++)
      add_item(3'(c), 8'($urandom), 1'($urandom), 1'($urandom));
    add_command(REQ_WRITE, 8'h96, 1'b0, BUS_RANDOM, 3, 1'b0);
    add_item(REQ_START, 8'hFF, 1'b1, 1'b1);
    add_item(REQ_TICK, 8'hFF, 1'b1, 1'b0);

    set_regs(16'd1, 8'd4, 8'd3);
    random_phase(250);
    set_regs(16'd2, 8'd1, 8'd0);
    random_phase(150);
    set_regs(16'd3, 8'd8, 8'd1);
    random_phase(150);
    set_regs(16'd1, 8'd255, 8'd255);
    add_command(REQ_WRITE, 8'hC3, 1'b0, BUS_HIGH, cmd_ticks(REQ_WRITE, BUS_HIGH) + 2, 1'b0);
    random_phase(50);

    // slowest unit: only the opening of a start fits, the rest is rejected
    set_regs(16'd65535, 8'd200, 8'd50);
    add_command(REQ_START, 8'h00, 1'b0, BUS_RANDOM, 20, 1'b1);
    add_command(REQ_READ, 8'hFF, 1'b1, BUS_RANDOM, 10, 1'b0);

    set_regs(16'd1, 8'd2, 8'd2);
    random_phase(150);

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
